>>> hw/rtl/clbw_pkg.sv
// clbw_pkg: shared types and constants for the character LCD backpack writer.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps

package clbw_pkg;

    localparam int INT_W = 32;

    typedef enum logic [1:0] {
        REQ_CMD    = 2'd0,
        REQ_DATA   = 2'd1,
        REQ_CURSOR = 2'd2,
        REQ_INT    = 2'd3
    } req_type_t;

    // expander bit map
    localparam logic [7:0] LCD_RS = 8'h01;
    localparam logic [7:0] LCD_EN = 8'h04;
    localparam logic [7:0] LCD_BL = 8'h08;

    localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
    localparam logic [7:0] ROW1_BASE     = 8'h40;
    localparam logic [7:0] CHAR_ZERO     = 8'h30;
    localparam logic [7:0] CHAR_MINUS    = 8'h2D;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_TRIM,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic conv;
        logic trim;
        logic next_char;
        logic push;
    } clbw_cmd_t;

    typedef struct packed {
        logic req_int;
        logic conv_last;
        logic trim_ok;
        logic beat_last;
        logic char_last;
        logic out_free;
    } clbw_sts_t;

endpackage

>>> hw/rtl/clbw_req_if.sv
// clbw_req_if: request channel (valid/ready plus request fields).
// Depends on nothing.
`timescale 1ns / 1ps

interface clbw_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic [7:0]         byte_value;
    logic               row;
    logic [5:0]         col;
    logic signed [31:0] int_value;

    modport source (
        output valid, req_type, byte_value, row, col, int_value,
        input  ready
    );
    modport sink (
        input  valid, req_type, byte_value, row, col, int_value,
        output ready
    );
endinterface

>>> hw/rtl/clbw_bus_if.sv
// clbw_bus_if: expander byte channel (valid/ready, bus_byte, last).
// Depends on nothing.
`timescale 1ns / 1ps

interface clbw_bus_if;
    logic       valid;
    logic       ready;
    logic [7:0] bus_byte;
    logic       last;

    modport source (
        output valid, bus_byte, last,
        input  ready
    );
    modport sink (
        input  valid, bus_byte, last,
        output ready
    );
endinterface

>>> hw/rtl/clbw_ctrl.sv
// clbw_ctrl: sequencer for load, binary-to-BCD conversion, zero trim and emit.
// Depends on clbw_pkg; drives the datapath through clbw_cmd_t.
`timescale 1ns / 1ps

module clbw_ctrl
    import clbw_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  clbw_sts_t sts,
    output clbw_cmd_t cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = sts.req_int ? ST_CONV : ST_EMIT;
                end
            end
            ST_CONV:
            begin
                if (sts.conv_last)
                begin
                    state_next = ST_TRIM;
                end
            end
            ST_TRIM:
            begin
                if (!sts.trim_ok)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free && sts.beat_last && sts.char_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                cmd.load  = req_valid;
            end
            ST_CONV:
            begin
                cmd.conv = 1'b1;
            end
            ST_TRIM:
            begin
                cmd.trim      = sts.trim_ok;
                cmd.next_char = !sts.trim_ok;
            end
            ST_EMIT:
            begin
                cmd.push      = sts.out_free;
                cmd.next_char = sts.out_free && sts.beat_last && !sts.char_last;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    a_load_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg != ST_IDLE)
        else $error("request load did not leave idle");

    a_final_beat_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.push && sts.beat_last && sts.char_last) |=> state_reg == ST_IDLE)
        else $error("final beat did not return to idle");

    a_conv_to_trim: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CONV && sts.conv_last) |=> state_reg == ST_TRIM)
        else $error("conversion end did not move to trim");

endmodule

>>> hw/rtl/clbw_dp.sv
// clbw_dp: request decode, double-dabble BCD converter, character and beat
// registers, output register. Depends on clbw_pkg; commanded by clbw_ctrl.
`timescale 1ns / 1ps

module clbw_dp
    import clbw_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [1:0]              req_type,
    input  logic [7:0]              byte_value,
    input  logic                    row,
    input  logic [5:0]              col,
    input  logic signed [INT_W-1:0] int_value,
    input  logic                    bus_ready,
    output logic                    bus_valid,
    output logic [7:0]              bus_byte,
    output logic                    bus_last,
    input  clbw_cmd_t               cmd,
    output clbw_sts_t               sts
);

    // decimal digits of 2**VALUE_WIDTH
    localparam int DIGITS = ((VALUE_WIDTH * 77) >> 8) + 1;
    localparam int BCDW   = DIGITS * 4;
    localparam int BCW    = $clog2(VALUE_WIDTH + 1);
    localparam int DCW    = $clog2(DIGITS + 1);

    logic [VALUE_WIDTH-1:0] val_reg,    val_next;
    logic [BCDW-1:0]        bcd_reg,    bcd_next;
    logic [BCW-1:0]         bitcnt_reg, bitcnt_next;
    logic [DCW-1:0]         dcnt_reg,   dcnt_next;
    logic                   pend_reg,   pend_next;
    logic [7:0]             char_reg,   char_next;
    logic                   rs_reg,     rs_next;
    logic [1:0]             beat_reg,   beat_next;
    logic                   ovld_reg,   ovld_next;
    logic [7:0]             obyte_reg,  obyte_next;
    logic                   olast_reg,  olast_next;

    logic [VALUE_WIDTH-1:0] raw;
    logic [VALUE_WIDTH-1:0] mag;
    logic                   neg;
    logic [7:0]             row_base;
    logic [7:0]             load_char;
    logic [BCDW-1:0]        bcd_adj;
    logic [3:0]             top_digit;
    logic [3:0]             nib;
    logic [7:0]             beat_byte;
    logic                   is_int;
    logic                   out_free;

    assign is_int    = req_type_t'(req_type) == REQ_INT;
    assign raw       = VALUE_WIDTH'(int_value);
    assign neg       = raw[VALUE_WIDTH-1];
    assign mag       = neg ? (~raw + VALUE_WIDTH'(1)) : raw;
    assign row_base  = row ? ROW1_BASE : 8'h00;
    assign top_digit = bcd_reg[BCDW-1 -: 4];
    assign out_free  = !ovld_reg || bus_ready;

    always_comb
    begin
        if (req_type_t'(req_type) == REQ_CURSOR)
        begin
            load_char = CMD_SET_DDRAM | (row_base + {2'b00, col});
        end
        else
        begin
            load_char = byte_value;
        end
    end

    always_comb
    begin
        logic [3:0] d;
        d = '0;
        for (int i = 0; i < DIGITS; i++)
        begin
            d = bcd_reg[i*4 +: 4];
            bcd_adj[i*4 +: 4] = (d >= 4'd5) ? (d + 4'd3) : d;
        end
    end

    // high nibble first, EN set then clear
    assign nib       = beat_reg[1] ? char_reg[3:0] : char_reg[7:4];
    assign beat_byte = {nib, 4'b0000} | LCD_BL
                     | (beat_reg[0] ? 8'h00 : LCD_EN)
                     | (rs_reg ? LCD_RS : 8'h00);

    always_comb
    begin
        val_next    = val_reg;
        bcd_next    = bcd_reg;
        bitcnt_next = bitcnt_reg;
        dcnt_next   = dcnt_reg;
        pend_next   = pend_reg;
        char_next   = char_reg;
        rs_next     = rs_reg;
        beat_next   = beat_reg;
        ovld_next   = ovld_reg;
        obyte_next  = obyte_reg;
        olast_next  = olast_reg;

        if (cmd.load)
        begin
            beat_next = 2'd0;
            if (is_int)
            begin
                val_next    = mag;
                pend_next   = neg;
                bcd_next    = '0;
                bitcnt_next = BCW'(VALUE_WIDTH);
                dcnt_next   = DCW'(DIGITS);
                rs_next     = 1'b1;
            end
            else
            begin
                char_next = load_char;
                pend_next = 1'b0;
                dcnt_next = '0;
                rs_next   = req_type_t'(req_type) == REQ_DATA;
            end
        end

        if (cmd.conv)
        begin
            bcd_next    = {bcd_adj[BCDW-2:0], val_reg[VALUE_WIDTH-1]};
            val_next    = {val_reg[VALUE_WIDTH-2:0], 1'b0};
            bitcnt_next = bitcnt_reg - BCW'(1);
        end

        if (cmd.trim)
        begin
            bcd_next  = {bcd_reg[BCDW-5:0], 4'h0};
            dcnt_next = dcnt_reg - DCW'(1);
        end

        if (cmd.push)
        begin
            ovld_next  = 1'b1;
            obyte_next = beat_byte;
            olast_next = (beat_reg == 2'd3) && (dcnt_reg == '0);
            beat_next  = beat_reg + 2'd1;
        end
        else if (bus_ready)
        begin
            ovld_next = 1'b0;
        end

        if (cmd.next_char)
        begin
            beat_next = 2'd0;
            if (pend_reg)
            begin
                char_next = CHAR_MINUS;
                pend_next = 1'b0;
            end
            else
            begin
                char_next = CHAR_ZERO | {4'h0, top_digit};
                bcd_next  = {bcd_reg[BCDW-5:0], 4'h0};
                dcnt_next = dcnt_reg - DCW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bitcnt_reg <= '0;
            dcnt_reg   <= '0;
            pend_reg   <= 1'b0;
            beat_reg   <= 2'd0;
            ovld_reg   <= 1'b0;
        end
        else
        begin
            bitcnt_reg <= bitcnt_next;
            dcnt_reg   <= dcnt_next;
            pend_reg   <= pend_next;
            beat_reg   <= beat_next;
            ovld_reg   <= ovld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg   <= val_next;
        bcd_reg   <= bcd_next;
        char_reg  <= char_next;
        rs_reg    <= rs_next;
        obyte_reg <= obyte_next;
        olast_reg <= olast_next;
    end

    assign sts.req_int   = is_int;
    assign sts.conv_last = bitcnt_reg == BCW'(1);
    assign sts.trim_ok   = (dcnt_reg > DCW'(1)) && (top_digit == 4'h0);
    assign sts.beat_last = beat_reg == 2'd3;
    assign sts.char_last = (dcnt_reg == '0) && !pend_reg;
    assign sts.out_free  = out_free;

    assign bus_valid = ovld_reg;
    assign bus_byte  = obyte_reg;
    assign bus_last  = olast_reg;

    a_push_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> out_free)
        else $error("beat pushed into occupied output register");

    a_next_char_has_src: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.next_char |-> (pend_reg || dcnt_reg != '0))
        else $error("character fetch with no digit or sign pending");

    a_conv_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.conv |-> bitcnt_reg != '0)
        else $error("conversion step past end of value");

endmodule

>>> hw/rtl/char_lcd_backpack_writer.sv
// Channel  Dir  Beat contents
// req      in   req_type, byte_value, row, col, int_value
// bus      out  bus_byte, last (last marks the final beat of a request)
//
// Command, character and cursor requests: a load, then 4 beats at one per cycle while
// the bus takes them. Integers: a load, double-dabble conversion, trim of up to DIGITS-1
// leading zeros and a first-character fetch, then 4 beats per printed character
// (up to 44 beats at VALUE_WIDTH = 32).
// One request at a time; a new request is taken once its last beat is in the output
// register. Output stalls hold the beat and pause the sequence. Reset idles both sides.
// Depends on clbw_pkg, clbw_req_if, clbw_bus_if, clbw_ctrl, clbw_dp.
`timescale 1ns / 1ps

module char_lcd_backpack_writer
    import clbw_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    clbw_req_if.sink  req,
    clbw_bus_if.source bus
);

    clbw_cmd_t cmd;
    clbw_sts_t sts;

    clbw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    clbw_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_type   (req.req_type),
        .byte_value (req.byte_value),
        .row        (req.row),
        .col        (req.col),
        .int_value  (req.int_value),
        .bus_ready  (bus.ready),
        .bus_valid  (bus.valid),
        .bus_byte   (bus.bus_byte),
        .bus_last   (bus.last),
        .cmd        (cmd),
        .sts        (sts)
    );

endmodule

>>> tb/tb_top.sv
// tb_top: self-checking testbench for char_lcd_backpack_writer (LCD expander byte stream).
// Uses clbw_pkg, clbw_req_if and clbw_bus_if from the RTL. Random requests with gaps and
// stalls on both sides; a scoreboard class predicts every expander beat.
`timescale 1ns / 1ps

module tb_top;
    import clbw_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES = 100;

    class lcd_beat_board;
        typedef struct packed {
            logic [7:0] bus_byte;
            logic       last;
        } beat_t;

        beat_t beat_q[$];
        int    errors;

        function new();
            errors = 0;
        endfunction

        function void push_nibble(logic [3:0] nib, logic rs);
            logic [7:0] b;
            b = LCD_BL | (rs ? LCD_RS : 8'h00) | {nib, 4'h0};
            beat_q.push_back('{bus_byte: b | LCD_EN, last: 1'b0});
            beat_q.push_back('{bus_byte: b & ~LCD_EN, last: 1'b0});
        endfunction

        function void push_char(logic [7:0] ch, logic rs);
            push_nibble(ch[7:4], rs);
            push_nibble(ch[3:0], rs);
        endfunction

        function void push_decimal(logic [INT_W-1:0] iv);
            logic [INT_W-1:0] mag;
            logic [3:0]       digs[$];
            if (iv == '0)
            begin
                push_char(CHAR_ZERO, 1'b1);
                return;
            end
            mag = iv;
            if (iv[INT_W-1])
            begin
                push_char(CHAR_MINUS, 1'b1);
                mag = -iv;
            end
            while (mag != '0)
            begin
                digs.push_front(4'(mag % 10));
                mag = mag / 10;
            end
            foreach (digs[i])
                push_char(CHAR_ZERO + {4'h0, digs[i]}, 1'b1);
        endfunction

        // expected beats for one accepted request
        function void note_request(req_type_t kind, logic [7:0] bv, logic row,
                                   logic [5:0] col, logic [INT_W-1:0] iv);
            beat_t tail;
            case (kind)
                REQ_CMD:    push_char(bv, 1'b0);
                REQ_DATA:   push_char(bv, 1'b1);
                REQ_CURSOR: push_char(CMD_SET_DDRAM |
                                      ((row ? ROW1_BASE : 8'h00) + {2'b00, col}), 1'b0);
                default:    push_decimal(iv);
            endcase
            tail = beat_q.pop_back();
            tail.last = 1'b1;
            beat_q.push_back(tail);
        endfunction

        function void check_beat(logic [7:0] bb, logic lst);
            beat_t exp_beat;
            if (beat_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected beat bus_byte=%02h last=%0b", $time, bb, lst);
                return;
            end
            exp_beat = beat_q.pop_front();
            if (bb !== exp_beat.bus_byte)
            begin
                errors++;
                $display("%0t: bus_byte expected %02h actual %02h",
                         $time, exp_beat.bus_byte, bb);
            end
            if (lst !== exp_beat.last)
            begin
                errors++;
                $display("%0t: last expected %0b actual %0b", $time, exp_beat.last, lst);
            end
        endfunction

        function int pending();
            return beat_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   idle_mode;
    bit   bus_hold_req;
    int   hold_cnt;
    int   stall_cnt;
    int   quiet_cycles;

    lcd_beat_board board = new();

    clbw_req_if req_ch();
    clbw_bus_if bus_ch();

    char_lcd_backpack_writer #(.VALUE_WIDTH(INT_W)) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .bus   (bus_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 92)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [INT_W-1:0] rand_int();
        logic [INT_W-1:0] v;
        case ($urandom_range(0, 5))
            0: v = $urandom;
            1: v = $urandom_range(0, 9);
            2: v = 32'h8000_0000 + $urandom_range(0, 3);
            3: v = 32'h7FFF_FFFF - $urandom_range(0, 3);
            default: v = $urandom >> $urandom_range(0, 31);
        endcase
        if ($urandom_range(0, 2) == 0)
            v = -v;
        return v;
    endfunction

    task automatic send_request(req_type_t kind, logic [7:0] bv, logic row,
                                logic [5:0] col, logic [INT_W-1:0] iv);
        int gap;
        gap = 0;
        if (idle_mode && $urandom_range(0, 1) == 1)
            gap = pick_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= kind;
        req_ch.byte_value <= bv;
        req_ch.row        <= row;
        req_ch.col        <= col;
        req_ch.int_value  <= iv;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        board.note_request(kind, bv, row, col, iv);
    endtask

    task automatic send_random();
        req_type_t kind;
        kind = req_type_t'($urandom_range(0, 3));
        send_request(kind, 8'($urandom), 1'($urandom), 6'($urandom), rand_int());
    endtask

    // expander side: check accepted beats, drive ready
    initial
    begin
        bus_ch.ready <= 1'b0;
        hold_cnt = 0;
        stall_cnt = 0;
        forever
        begin
            @(posedge clk);
            if (bus_ch.valid && bus_ch.ready)
                board.check_beat(bus_ch.bus_byte, bus_ch.last);
            if (bus_hold_req)
            begin
                hold_cnt = HOLD_OFF_CYCLES;
                bus_hold_req = 1'b0;
            end
            if (!rst_n)
                bus_ch.ready <= 1'b0;
            else if (hold_cnt > 0)
            begin
                hold_cnt--;
                bus_ch.ready <= 1'b0;
            end
            else if (!idle_mode)
                bus_ch.ready <= 1'b1;
            else if (stall_cnt > 0)
            begin
                stall_cnt--;
                bus_ch.ready <= 1'b0;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                stall_cnt = pick_gap() - 1;
                bus_ch.ready <= 1'b0;
            end
            else
                bus_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (bus_ch.valid && bus_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        idle_mode = 1'b0;
        bus_hold_req = 1'b0;
        rst_n <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.req_type   <= REQ_CMD;
        req_ch.byte_value <= 8'h00;
        req_ch.row        <= 1'b0;
        req_ch.col        <= 6'd0;
        req_ch.int_value  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, no idling
        send_request(REQ_CMD, 8'h00, 1'($urandom), 6'($urandom), $urandom);
        send_request(REQ_CMD, 8'hFF, 1'($urandom), 6'($urandom), $urandom);
        send_request(REQ_CMD, 8'hA5, 1'($urandom), 6'($urandom), $urandom);
        send_request(REQ_DATA, 8'h00, 1'($urandom), 6'($urandom), $urandom);
        send_request(REQ_DATA, 8'hFF, 1'($urandom), 6'($urandom), $urandom);
        send_request(REQ_DATA, 8'h5A, 1'($urandom), 6'($urandom), $urandom);
        send_request(REQ_CURSOR, 8'($urandom), 1'b0, 6'd0, $urandom);
        send_request(REQ_CURSOR, 8'($urandom), 1'b1, 6'd63, $urandom);
        send_request(REQ_CURSOR, 8'($urandom), 1'b0, 6'd63, $urandom);
        send_request(REQ_CURSOR, 8'($urandom), 1'b1, 6'd0, $urandom);
        send_request(REQ_INT, 8'($urandom), 1'($urandom), 6'($urandom), 32'd0);
        send_request(REQ_INT, 8'($urandom), 1'($urandom), 6'($urandom), 32'd1);
        send_request(REQ_INT, 8'($urandom), 1'($urandom), 6'($urandom), -32'sd1);
        send_request(REQ_INT, 8'($urandom), 1'($urandom), 6'($urandom), 32'd9);
        send_request(REQ_INT, 8'($urandom), 1'($urandom), 6'($urandom), 32'd10);
        send_request(REQ_INT, 8'($urandom), 1'($urandom), 6'($urandom), -32'sd10);
        send_request(REQ_INT, 8'($urandom), 1'($urandom), 6'($urandom), 32'h7FFF_FFFF);
        send_request(REQ_INT, 8'($urandom), 1'($urandom), 6'($urandom), 32'h8000_0000);
        send_request(REQ_INT, 8'($urandom), 1'($urandom), 6'($urandom), 32'h8000_0001);
        send_request(REQ_INT, 8'($urandom), 1'($urandom), 6'($urandom), 32'd1000000000);
        send_request(REQ_INT, 8'($urandom), 1'($urandom), 6'($urandom), 32'd12345);

        idle_mode = 1'b1;
        for (int i = 0; i < 140; i++)
        begin
            if (i == 50)
                bus_hold_req = 1'b1;
            if (i == 100)
                idle_mode = 1'b0;
            if (i == 130)
                idle_mode = 1'b1;
            send_random();
        end
        req_ch.valid <= 1'b0;

        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> char_lcd_backpack_writer.f
hw/rtl/clbw_pkg.sv
hw/rtl/clbw_req_if.sv
hw/rtl/clbw_bus_if.sv
hw/rtl/clbw_ctrl.sv
hw/rtl/clbw_dp.sv
hw/rtl/char_lcd_backpack_writer.sv
tb/tb_top.sv
